// ----- sv/ctl_pkg.sv -----
// Closed tour length: shared types and constants.
// Used by ctl_front, ctl_queue, ctl_back and closed_tour_length_top.
package ctl_pkg;

  localparam int CoordW = 16;
  localparam int NodeW  = 5;
  localparam int EntryW = 16;
  localparam int LenW   = 32;

  // request kinds
  localparam logic OP_ELEM  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // distance modes
  localparam logic MODE_COORD  = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  // register index (word address bit)
  localparam logic REG_DISTANCE_MODE = 1'b0;

  typedef struct packed {
    logic                     op;
    logic                     mode;
    logic                     start;    // first element of a tour, no leg in
    logic                     last;     // closing leg and result
    logic signed [CoordW-1:0] cur_x;
    logic signed [CoordW-1:0] cur_y;
    logic [NodeW-1:0]         cur_node;
    logic signed [CoordW-1:0] prv_x;
    logic signed [CoordW-1:0] prv_y;
    logic [NodeW-1:0]         prv_node;
    logic signed [CoordW-1:0] fst_x;
    logic signed [CoordW-1:0] fst_y;
    logic [NodeW-1:0]         fst_node;
    logic [NodeW-1:0]         row;
    logic [NodeW-1:0]         col;
    logic [EntryW-1:0]        value;
  } cmd_t;

endpackage

// ----- sv/ctl_front.sv -----
// Closed tour length: front end. Accepts requests, tracks tour position
// (first and previous element) and builds commands. Depends on ctl_pkg.
module ctl_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            opcode,
  input  logic signed [ctl_pkg::CoordW-1:0] x_coord,
  input  logic signed [ctl_pkg::CoordW-1:0] y_coord,
  input  logic [ctl_pkg::NodeW-1:0]       node_index,
  input  logic [ctl_pkg::NodeW-1:0]       row_index,
  input  logic [ctl_pkg::NodeW-1:0]       col_index,
  input  logic [ctl_pkg::EntryW-1:0]      entry_value,
  input  logic                            last,
  input  logic                            mode,
  input  logic                            q_full,
  output logic                            full,
  output logic                            q_push,
  output ctl_pkg::cmd_t                   q_data
);
  import ctl_pkg::*;

  logic                     started;
  logic signed [CoordW-1:0] first_x;
  logic signed [CoordW-1:0] first_y;
  logic [NodeW-1:0]         first_node;
  logic signed [CoordW-1:0] prev_x;
  logic signed [CoordW-1:0] prev_y;
  logic [NodeW-1:0]         prev_node;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data          = '0;
    q_data.op       = opcode;
    q_data.mode     = mode;
    q_data.start    = !started;
    q_data.last     = last;
    q_data.cur_x    = x_coord;
    q_data.cur_y    = y_coord;
    q_data.cur_node = node_index;
    q_data.prv_x    = prev_x;
    q_data.prv_y    = prev_y;
    q_data.prv_node = prev_node;
    q_data.row      = row_index;
    q_data.col      = col_index;
    q_data.value    = entry_value;
    if (started) begin
      q_data.fst_x    = first_x;
      q_data.fst_y    = first_y;
      q_data.fst_node = first_node;
    end else begin
      q_data.fst_x    = x_coord;
      q_data.fst_y    = y_coord;
      q_data.fst_node = node_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (q_push && opcode == OP_ELEM) begin
      started <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push && opcode == OP_ELEM) begin
      if (!started) begin
        first_x    <= x_coord;
        first_y    <= y_coord;
        first_node <= node_index;
      end
      prev_x    <= x_coord;
      prev_y    <= y_coord;
      prev_node <= node_index;
    end
  end

endmodule

// ----- sv/ctl_queue.sv -----
// Closed tour length: two-entry command queue between front and back end.
// Depends on ctl_pkg.
module ctl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctl_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output ctl_pkg::cmd_t rdata,
  output logic          empty
);
  import ctl_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = 1;

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full  = (count == (PtrW+1)'(Depth));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ctl_back.sv -----
// Closed tour length: back end. Holds the distance matrix, computes legs
// (squares, bit-serial square root or matrix read), saturating sum and the
// result register. Depends on ctl_pkg.
module ctl_back #(
  parameter int MAX_NODES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  ctl_pkg::cmd_t            q_data,
  output logic                     q_pop,
  input  logic                     pop,
  output logic                     empty,
  output logic [ctl_pkg::LenW-1:0] tour_length
);
  import ctl_pkg::*;

  localparam int IW    = $clog2(MAX_NODES);
  localparam int ExtW  = (IW + 1 > NodeW) ? IW + 1 : NodeW;
  localparam int Depth = 2 ** (2 * IW);
  localparam int SqW   = 2 * (CoordW + 1);   // square and root working width
  localparam int RootW = CoordW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SQX  = 3'd2;
  localparam logic [2:0] S_SQY  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic [SqW-1:0] BitStart = SqW'(1) << (SqW - 2);

  logic [2:0]          state;
  cmd_t                cmd;
  logic                leg_sel;     // 0: previous to current, 1: closing leg
  logic [SqW-1:0]      rem;
  logic [SqW-1:0]      root;
  logic [SqW-1:0]      bitv;
  logic [LenW-1:0]     sum;
  logic                out_valid;
  logic                emit_now;
  logic [EntryW-1:0]   mem_q;
  logic [EntryW-1:0]   mem [Depth];

  // leg operand selection
  logic signed [CoordW-1:0] ax, ay, bx, by;
  logic [NodeW-1:0]         an, bn;
  logic signed [CoordW:0]   dx, dy, mul_in;
  logic signed [SqW-1:0]    sq;
  logic [SqW-1:0]           trial;
  logic [2:0]               leg_first;
  logic [ExtW-1:0]          rd_r, rd_c, wr_r, wr_c;
  logic                     rd_ok, wr_ok;
  logic [2*IW-1:0]          rd_addr, wr_addr;
  logic [RootW-1:0]         leg_val;
  logic [LenW:0]            sum_wide;

  always_comb begin
    if (leg_sel) begin
      ax = cmd.cur_x;  ay = cmd.cur_y;  an = cmd.cur_node;
      bx = cmd.fst_x;  by = cmd.fst_y;  bn = cmd.fst_node;
    end else begin
      ax = cmd.prv_x;  ay = cmd.prv_y;  an = cmd.prv_node;
      bx = cmd.cur_x;  by = cmd.cur_y;  bn = cmd.cur_node;
    end
  end

  assign dx     = $signed({ax[CoordW-1], ax}) - $signed({bx[CoordW-1], bx});
  assign dy     = $signed({ay[CoordW-1], ay}) - $signed({by[CoordW-1], by});
  assign mul_in = (state == S_SQX) ? dx : dy;
  assign sq     = mul_in * mul_in;
  assign trial  = root + bitv;

  assign leg_first = (cmd.mode == MODE_MATRIX) ? S_RD : S_SQX;

  assign rd_r    = ExtW'(an);
  assign rd_c    = ExtW'(bn);
  assign wr_r    = ExtW'(cmd.row);
  assign wr_c    = ExtW'(cmd.col);
  assign rd_ok   = (rd_r < ExtW'(MAX_NODES)) && (rd_c < ExtW'(MAX_NODES));
  assign wr_ok   = (wr_r < ExtW'(MAX_NODES)) && (wr_c < ExtW'(MAX_NODES));
  assign rd_addr = {rd_r[IW-1:0], rd_c[IW-1:0]};
  assign wr_addr = {wr_r[IW-1:0], wr_c[IW-1:0]};

  always_comb begin
    if (cmd.mode == MODE_MATRIX) begin
      leg_val = rd_ok ? RootW'(mem_q) : '0;
    end else begin
      leg_val = root[RootW-1:0];
    end
  end

  assign sum_wide = {1'b0, sum} + (LenW+1)'(leg_val);

  assign q_pop       = (state == S_IDLE) && !q_empty;
  assign empty       = !out_valid;
  assign emit_now    = (state == S_EMIT) && (!out_valid || pop);

  // matrix storage
  always_ff @(posedge clk) begin
    if (state == S_DISP && cmd.op == OP_WRITE && wr_ok) begin
      mem[wr_addr] <= cmd.value;
    end
    if (state == S_RD) begin
      mem_q <= mem[rd_addr];
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    unique case (state)
      S_SQX: begin
        rem <= $unsigned(sq);
      end
      S_SQY: begin
        rem  <= rem + $unsigned(sq);
        root <= '0;
        bitv <= BitStart;
      end
      S_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      default: begin
      end
    endcase
  end

  // result register: loads a new total as the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      tour_length <= sum;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      leg_sel   <= 1'b0;
      sum       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (cmd.op == OP_WRITE) begin
            state <= S_IDLE;
          end else begin
            if (cmd.start) begin
              sum <= '0;
            end
            if (!cmd.start) begin
              leg_sel <= 1'b0;
              state   <= leg_first;
            end else if (cmd.last) begin
              leg_sel <= 1'b1;
              state   <= leg_first;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_ROOT;
        S_ROOT: begin
          if (bitv[0]) begin
            state <= S_ADD;
          end
        end
        S_RD:   state <= S_ADD;
        S_ADD: begin
          sum <= sum_wide[LenW] ? '1 : sum_wide[LenW-1:0];
          if (!leg_sel && cmd.last) begin
            leg_sel <= 1'b1;
            state   <= leg_first;
          end else if (cmd.last) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/closed_tour_length_top.sv -----
// Closed tour length: top level with the configuration register.
// Instantiates ctl_front, ctl_queue and ctl_back; depends on ctl_pkg.
//
//  channel   handshake            payload
//  --------  -------------------  -----------------------------------------
//  request   push / full          opcode, x_coord, y_coord, node_index,
//                                 row_index, col_index, entry_value, last
//  result    empty / pop          tour_length
//  config    psel/penable/pwrite  paddr, pwdata, prdata (distance_mode @0)
//
// Steps: a matrix write or a legless element is only dispatched; a matrix
// leg reads, then adds; a coordinate leg squares dx and dy, takes the
// bit-serial square root, then adds; a last element adds its closing leg and emits.
// Reset (rst, synchronous) clears mode, tour position, queue and result;
// the distance matrix is undefined until written. An unpopped result stalls
// the back end only once the next result is ready; the queue fills, full rises.
module closed_tour_length_top #(
  parameter int MAX_NODES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             push,
  output logic                             full,
  input  logic                             opcode,
  input  logic signed [ctl_pkg::CoordW-1:0] x_coord,
  input  logic signed [ctl_pkg::CoordW-1:0] y_coord,
  input  logic [ctl_pkg::NodeW-1:0]        node_index,
  input  logic [ctl_pkg::NodeW-1:0]        row_index,
  input  logic [ctl_pkg::NodeW-1:0]        col_index,
  input  logic [ctl_pkg::EntryW-1:0]       entry_value,
  input  logic                             last,
  // result channel
  output logic                             empty,
  input  logic                             pop,
  output logic [ctl_pkg::LenW-1:0]         tour_length,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ctl_pkg::*;

  logic distance_mode;
  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_wdata, q_rdata;

  // Configuration: word address bit 2 selects the register; low byte bits
  // are ignored. Always ready, no wait states.
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_DISTANCE_MODE) begin
      prdata = {31'b0, distance_mode};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= MODE_COORD;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_DISTANCE_MODE) begin
      distance_mode <= pwdata[0];
    end
  end

  // Front end: tags each request with tour position and the current mode.
  ctl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .opcode      (opcode),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .node_index  (node_index),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .last        (last),
    .mode        (distance_mode),
    .q_full      (q_full),
    .full        (full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Decoupling queue.
  ctl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: matrix, leg arithmetic, sum and result register.
  ctl_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .tour_length (tour_length)
  );

endmodule
